@@ design/max_pool_2x2_scale_bias_assert.svh @@
// assertion macros shared by the checker
`ifndef MAX_POOL_2X2_SCALE_BIAS_ASSERT_SVH
`define MAX_POOL_2X2_SCALE_BIAS_ASSERT_SVH

// same-cycle implication
`define MP2SB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MP2SB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mp2sb_pkg.sv @@
`timescale 1ns / 1ps

package mp2sb_pkg;

  localparam int DefMaxRowWidth = 1024;
  localparam int DefPixelBits   = 16;

  localparam int MaxFrameHeight = 1024;
  localparam int RowBits        = 10;
  localparam int HeightBits     = 11;
  localparam int SizeBits       = 11;
  localparam int CoefBits       = 16;
  localparam int CfgIdxBits     = 2;

  localparam int RstRowWidth    = 28;
  localparam int RstFrameHeight = 28;
  localparam int RstGain        = 256;
  localparam int RstBias        = 0;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_ROW_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_GAIN         = 2'd2,
    REG_BIAS         = 2'd3
  } cfg_reg_e;

endpackage

@@ design/max_pool_2x2_scale_bias.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata pixel, tuser frame_start
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata pooled_value, tuser row_end,
//                                                    tlast frame_end
// cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i register, cfg_data_i value
//
// one pixel per cycle while the output is not stalled; the pixel that completes a block
// passes the line store read, max, multiply, and round and saturate registers in order
// one write and one read port on the line store; read per pixel, write per even-row pair
// reset clears counters, pair max and valids; the line store holds no reset value
// a stalled output only holds the input once every stage behind it is full

module max_pool_2x2_scale_bias #(
  parameter int MAX_ROW_WIDTH = mp2sb_pkg::DefMaxRowWidth,
  parameter int PIXEL_BITS    = mp2sb_pkg::DefPixelBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [PIXEL_BITS-1:0] pixel, zero fill above
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // [0] frame_start
  input  logic [0:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [PIXEL_BITS-1:0] pooled_value, zero fill above
  output logic [((PIXEL_BITS+7)/8)*8-1:0]       m_axis_tdata,
  // [0] row_end
  output logic [0:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mp2sb_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [mp2sb_pkg::CoefBits-1:0]        cfg_data_i
);

  localparam int TdataW    = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int CW        = $clog2(MAX_ROW_WIDTH + 1);
  localparam int CntW      = $clog2(MAX_ROW_WIDTH);
  localparam int LineDepth = MAX_ROW_WIDTH / 2;
  localparam int IdxW      = $clog2(LineDepth);
  localparam int RW        = mp2sb_pkg::RowBits;
  localparam int HW        = mp2sb_pkg::HeightBits;
  localparam int GW        = mp2sb_pkg::CoefBits;
  localparam int PW        = PIXEL_BITS + GW;
  localparam int SW        = PW + 1;
  localparam int QW        = SW - 8;
  localparam int RstW      = (mp2sb_pkg::RstRowWidth > MAX_ROW_WIDTH) ?
                             MAX_ROW_WIDTH : mp2sb_pkg::RstRowWidth;

  // configuration, stored already clamped
  logic [CW-1:0]        width_q;
  logic [HW-1:0]        height_q;
  logic signed [GW-1:0] gain_q;
  logic signed [GW-1:0] bias_q;
  logic [12:0]          cfg_w13;
  logic [HW-1:0]        cfg_h;

  assign cfg_ready_o = 1'b1;
  assign cfg_w13     = {2'b00, cfg_data_i[mp2sb_pkg::SizeBits-1:0]};
  assign cfg_h       = cfg_data_i[mp2sb_pkg::SizeBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(RstW);
      height_q <= HW'(mp2sb_pkg::RstFrameHeight);
      gain_q   <= GW'(mp2sb_pkg::RstGain);
      bias_q   <= GW'(mp2sb_pkg::RstBias);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mp2sb_pkg::cfg_reg_e'(cfg_index_i))
        mp2sb_pkg::REG_ROW_WIDTH: begin
          if (cfg_w13 < 13'd2) width_q <= CW'(2);
          else if (cfg_w13 > 13'(MAX_ROW_WIDTH)) width_q <= CW'(MAX_ROW_WIDTH);
          else width_q <= cfg_w13[CW-1:0];
        end
        mp2sb_pkg::REG_FRAME_HEIGHT: begin
          if (cfg_h < HW'(2)) height_q <= HW'(2);
          else if (cfg_h > HW'(mp2sb_pkg::MaxFrameHeight))
            height_q <= HW'(mp2sb_pkg::MaxFrameHeight);
          else height_q <= cfg_h;
        end
        mp2sb_pkg::REG_GAIN: gain_q <= cfg_data_i;
        mp2sb_pkg::REG_BIAS: bias_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic rdy_out, rdy3, rdy2, rdy1;
  logic s_fire;

  assign rdy_out       = !out_valid_q || m_axis_tready;
  assign rdy3          = !v3_q || rdy_out;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // position of the incoming pixel
  logic [CntW-1:0]              col_q;
  logic [RW-1:0]                row_q;
  logic [CntW-1:0]              col0;
  logic [RW-1:0]                row0;
  logic [CW-1:0]                col_ext, col_inc, width_even;
  logic [HW-1:0]                row_ext, row_inc, height_even;
  logic                         in_block, line_wr, emit, row_end0, frame_end0;
  logic [IdxW-1:0]              idx;
  logic signed [PIXEL_BITS-1:0] pixel, pair_max_q, pm;

  assign pixel       = s_axis_tdata[PIXEL_BITS-1:0];
  assign col0        = s_axis_tuser[0] ? '0 : col_q;
  assign row0        = s_axis_tuser[0] ? '0 : row_q;
  assign col_ext     = CW'(col0);
  assign row_ext     = HW'(row0);
  assign col_inc     = col_ext + CW'(1);
  assign row_inc     = row_ext + HW'(1);
  assign width_even  = {width_q[CW-1:1], 1'b0};
  assign height_even = {height_q[HW-1:1], 1'b0};
  assign in_block    = (col_ext < width_even) && (row_ext < height_even);
  assign idx         = col0[CntW-1:1];
  assign pm          = (pixel > pair_max_q) ? pixel : pair_max_q;
  assign line_wr     = s_fire && in_block && col0[0] && !row0[0];
  assign emit        = in_block && col0[0] && row0[0];
  assign row_end0    = col_ext == (width_even - CW'(1));
  assign frame_end0  = row_end0 && (row_ext == (height_even - HW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      pair_max_q <= '0;
    end else if (s_fire) begin
      if (in_block && !col0[0]) pair_max_q <= pixel;
      if (col_inc >= width_q) begin
        col_q <= '0;
        row_q <= (row_inc >= height_q) ? '0 : row_inc[RW-1:0];
      end else begin
        col_q <= col_inc[CntW-1:0];
        row_q <= row0;
      end
    end
  end

  // line store of even-row pair maxima
  logic [PIXEL_BITS-1:0] line_mem [LineDepth];
  logic [PIXEL_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (line_wr) line_mem[idx] <= pm;
    if (s_fire) rd_q <= line_mem[idx];
  end

  // stage 1: pair max and flags beside the line store read
  logic signed [PIXEL_BITS-1:0] m1_q, mx2_q;
  logic                         re1_q, fe1_q, re2_q, fe2_q, re3_q, fe3_q;
  logic signed [PW-1:0]         prod3_q;
  logic signed [PIXEL_BITS-1:0] line_val;

  assign line_val = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_fire && emit;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy_out) out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      m1_q  <= pm;
      re1_q <= row_end0;
      fe1_q <= frame_end0;
    end
    if (v1_q && rdy2) begin
      mx2_q <= (line_val > m1_q) ? line_val : m1_q;
      re2_q <= re1_q;
      fe2_q <= fe1_q;
    end
    if (v2_q && rdy3) begin
      prod3_q <= gain_q * mx2_q;
      re3_q   <= re2_q;
      fe3_q   <= fe2_q;
    end
  end

  // round to nearest and saturate
  logic signed [SW-1:0]   sum;
  logic signed [QW-1:0]   quo;
  logic [QW-PIXEL_BITS:0] top;
  logic [PIXEL_BITS-1:0]  sat;
  logic [PIXEL_BITS-1:0]  out_val_q;
  logic                   out_re_q, out_fe_q;

  assign sum = SW'(prod3_q) + (SW'(bias_q) <<< 8) + SW'(128);
  assign quo = sum[SW-1:8];
  assign top = quo[QW-1:PIXEL_BITS-1];

  always_comb begin
    if ((&top) || !(|top)) sat = quo[PIXEL_BITS-1:0];
    else if (quo[QW-1]) sat = {1'b1, {(PIXEL_BITS-1){1'b0}}};
    else sat = {1'b0, {(PIXEL_BITS-1){1'b1}}};
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && rdy_out) begin
      out_val_q <= sat;
      out_re_q  <= re3_q;
      out_fe_q  <= fe3_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TdataW'(out_val_q);
  assign m_axis_tuser  = out_re_q;
  assign m_axis_tlast  = out_fe_q;

endmodule

@@ design/mp2sb_checker.sv @@
`timescale 1ns / 1ps
`include "max_pool_2x2_scale_bias_assert.svh"

module mp2sb_checker #(
  parameter int PIXEL_BITS = mp2sb_pkg::DefPixelBits
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((PIXEL_BITS+7)/8)*8-1:0]   m_axis_tdata,
  input logic [0:0]                        m_axis_tuser,
  input logic                              m_axis_tlast,
  input logic                              cfg_ready_o
);

  `MP2SB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output transfer changed")
  `MP2SB_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
  `MP2SB_ASSERT_NOW(a_frame_end_row_end, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0], "frame end without row end")
  `MP2SB_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o, "config port not ready")

endmodule

bind max_pool_2x2_scale_bias mp2sb_checker #(.PIXEL_BITS(PIXEL_BITS)) u_mp2sb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_ready_o   (cfg_ready_o)
);

@@ test/tb_max_pool_2x2_scale_bias.sv @@
`timescale 1ns / 1ps

module tb_max_pool_2x2_scale_bias;
  import mp2sb_pkg::*;

  localparam int PixBits      = DefPixelBits;
  localparam int LineDepth    = DefMaxRowWidth / 2;
  localparam longint PixMax   = (longint'(1) <<< (PixBits - 1)) - 1;
  localparam longint PixMin   = -PixMax - 1;
  localparam int SettleCycles = 12;
  localparam int HoldCycles   = 300;
  localparam int NumPhases    = 6;

  typedef struct packed {
    logic [PixBits-1:0] value;
    logic               row_end;
    logic               frame_end;
  } pool_res_t;

  typedef struct packed {
    logic      typed;
    pool_res_t res;
  } pixel_tag_t;

  typedef enum logic {
    ROW_CFG,
    ROW_PIXEL
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    cfg_reg_e           sel;
    logic [15:0]        data;
    logic               fs;
    logic               typed;
    logic [PixBits-1:0] exp_value;
    logic               exp_re;
    logic               exp_fe;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] gain;
    logic [15:0] bias;
    int          items;
    int          send_idle;
    int          recv_stall;
    logic        pressure;
  } phase_t;

  localparam int DirRows = 37;
  localparam dir_row_t DirTab [DirRows] = '{
    '{ROW_CFG,   REG_ROW_WIDTH,    16'd2,    1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CFG,   REG_FRAME_HEIGHT, 16'd2,    1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    // field extremes, block max is the largest pixel
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h7FFF, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h0001, 1'b0, 1'b1, 16'h7FFF, 1'b1, 1'b1},
    // largest gain and bias saturate high
    '{ROW_CFG,   REG_GAIN,         16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CFG,   REG_BIAS,         16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h0100, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h8000, 1'b0, 1'b1, 16'h7FFF, 1'b1, 1'b1},
    // most negative gain and bias saturate low
    '{ROW_CFG,   REG_GAIN,         16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CFG,   REG_BIAS,         16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h0100, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h0100, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h0100, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h0100, 1'b0, 1'b1, 16'h8000, 1'b1, 1'b1},
    // half gain, tie rounds up; width zero is taken as two
    '{ROW_CFG,   REG_GAIN,         16'h0080, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CFG,   REG_BIAS,         16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CFG,   REG_ROW_WIDTH,    16'd0,    1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h8000, 1'b0, 1'b1, 16'h0001, 1'b1, 1'b1},
    // odd width and height, trailing column and row dropped
    '{ROW_CFG,   REG_GAIN,         16'h0100, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CFG,   REG_ROW_WIDTH,    16'd3,    1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CFG,   REG_FRAME_HEIGHT, 16'd3,    1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h1234, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'hFEDC, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h7000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h0042, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h8001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, REG_ROW_WIDTH,    16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [CoefBits-1:0]   cfg_data_i  = '0;

  // predictor state and register copies
  logic [SizeBits-1:0]        cur_width  = SizeBits'(RstRowWidth);
  logic [SizeBits-1:0]        cur_height = SizeBits'(RstFrameHeight);
  logic signed [CoefBits-1:0] cur_gain   = CoefBits'(RstGain);
  logic signed [CoefBits-1:0] cur_bias   = CoefBits'(RstBias);
  int unsigned                col_pos    = 0;
  int unsigned                row_pos    = 0;
  logic signed [PixBits-1:0]  pair_hi    = '0;
  logic signed [PixBits-1:0]  line_hi [LineDepth];

  pool_res_t   pooled_q [$];
  pixel_tag_t  pixel_tags [$];
  int unsigned mismatch_count = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  logic        hold_on    = 1'b0;
  int          held_cycles = 0;
  phase_t      phases [NumPhases];

  max_pool_2x2_scale_bias uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("max_pool_2x2_scale_bias verification failed");
    $finish;
  end

  function automatic logic pool_pixel(input logic signed [PixBits-1:0] px, input logic fs,
                                      output pool_res_t res);
    int unsigned w, h, ow, oh, idx;
    logic signed [PixBits-1:0] m;
    longint s;
    logic hit;
    hit = 1'b0;
    res = '0;
    w = (cur_width < 2) ? 2 : (cur_width > DefMaxRowWidth) ? DefMaxRowWidth : cur_width;
    h = (cur_height < 2) ? 2 : (cur_height > MaxFrameHeight) ? MaxFrameHeight : cur_height;
    ow = w / 2;
    oh = h / 2;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos < 2 * ow && row_pos < 2 * oh) begin
      idx = col_pos >> 1;
      if (!col_pos[0]) begin
        pair_hi = px;
      end else begin
        m = (px > pair_hi) ? px : pair_hi;
        if (!row_pos[0]) begin
          line_hi[idx] = m;
        end else begin
          if (line_hi[idx] > m) m = line_hi[idx];
          s = longint'(cur_gain) * longint'(m) + longint'(cur_bias) * 256 + 128;
          s = s >>> 8;
          if (s > PixMax) s = PixMax;
          else if (s < PixMin) s = PixMin;
          res.value = s[PixBits-1:0];
          res.row_end = (idx == ow - 1);
          res.frame_end = res.row_end && ((row_pos >> 1) == oh - 1);
          hit = 1'b1;
        end
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return hit;
  endfunction

  // register writes, pixel transfers and pooled results, in that order per edge
  always @(posedge clk_i) begin : track_p
    pixel_tag_t tag;
    pool_res_t  calc;
    pool_res_t  want;
    logic       hit;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROW_WIDTH:    cur_width  = cfg_data_i[SizeBits-1:0];
        REG_FRAME_HEIGHT: cur_height = cfg_data_i[SizeBits-1:0];
        REG_GAIN:         cur_gain   = cfg_data_i;
        REG_BIAS:         cur_bias   = cfg_data_i;
        default: ;
      endcase
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tag = pixel_tags.pop_front();
      hit = pool_pixel(s_axis_tdata[PixBits-1:0], s_axis_tuser[0], calc);
      if (tag.typed) pooled_q = {pooled_q, tag.res};
      else if (hit) pooled_q = {pooled_q, calc};
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pooled_q.size() == 0) begin
        $display("%0t: unexpected pooled result %h row_end %b frame_end %b",
                 $time, m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
        mismatch_count++;
      end else begin
        want = pooled_q.pop_front();
        if (m_axis_tdata[PixBits-1:0] !== want.value) begin
          $display("%0t: pooled_value expected %h got %h", $time, want.value,
                   m_axis_tdata[PixBits-1:0]);
          mismatch_count++;
        end
        if (m_axis_tuser[0] !== want.row_end) begin
          $display("%0t: row_end expected %b got %b", $time, want.row_end, m_axis_tuser[0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.frame_end) begin
          $display("%0t: frame_end expected %b got %b", $time, want.frame_end, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_on && held_cycles < HoldCycles) begin
      m_axis_tready <= 1'b0;
      held_cycles <= held_cycles + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_pixel(input logic [15:0] px, input logic fs, input pixel_tag_t tag);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    pixel_tags = {pixel_tags, tag};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // leaves cfg_valid_i high so back-to-back writes need no gap
  task automatic write_reg(input cfg_reg_e sel, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pooled_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    pixel_tag_t tag;
    logic [31:0] rnd;
    logic [15:0] px;
    logic fs;
    foreach (line_hi[i]) line_hi[i] = '0;
    phases[0] = '{16'd2047, 16'd0, 16'($urandom_range(64, 512)), 16'($urandom),
                  1040, 0, 0, 1'b0};
    phases[1] = '{16'd6, 16'd4, 16'($urandom), 16'($urandom_range(0, 255)),
                  120, 88, 0, 1'b0};
    phases[2] = '{16'd8, 16'd6, 16'(-$urandom_range(1, 512)), 16'($urandom),
                  120, 0, 88, 1'b0};
    phases[3] = '{16'd5, 16'd5, 16'($urandom_range(128, 384)), 16'(-$urandom_range(0, 255)),
                  120, 15, 15, 1'b0};
    phases[4] = '{16'd2, 16'd2047, 16'($urandom), 16'($urandom),
                  120, 15, 0, 1'b0};
    phases[5] = '{16'd4, 16'd2, 16'd256, 16'd0, 150, 0, 0, 1'b1};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) begin
      if (DirTab[i].kind == ROW_CFG) begin
        if (i == 0 || DirTab[i-1].kind != ROW_CFG) settle();
        write_reg(DirTab[i].sel, DirTab[i].data);
      end else begin
        cfg_valid_i <= 1'b0;
        tag.typed = DirTab[i].typed;
        tag.res   = '{DirTab[i].exp_value, DirTab[i].exp_re, DirTab[i].exp_fe};
        send_pixel(DirTab[i].data, DirTab[i].fs, tag);
      end
    end

    foreach (phases[p]) begin
      settle();
      write_reg(REG_ROW_WIDTH, phases[p].width);
      write_reg(REG_FRAME_HEIGHT, phases[p].height);
      write_reg(REG_GAIN, phases[p].gain);
      write_reg(REG_BIAS, phases[p].bias);
      cfg_valid_i <= 1'b0;
      idle_pct  = phases[p].send_idle;
      stall_pct <= phases[p].recv_stall;
      hold_on   <= phases[p].pressure;
      tag = '0;
      for (int k = 0; k < phases[p].items; k++) begin
        rnd = $urandom;
        // a fresh frame after every size change keeps line store reads on written entries
        fs = (k == 0) || ($urandom_range(63) == 0);
        px = ($urandom_range(3) == 0) ? {{6{rnd[9]}}, rnd[9:0]} : rnd[15:0];
        send_pixel(px, fs, tag);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("max_pool_2x2_scale_bias verification clean");
    end else begin
      $display("max_pool_2x2_scale_bias verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/mp2sb_pkg.sv
design/max_pool_2x2_scale_bias.sv
design/mp2sb_checker.sv
test/tb_max_pool_2x2_scale_bias.sv
